[hdl/frustum_cull_sphere_box_defines.svh]
// assertion macros for the frustum culling block
// used by the checker; depends on nothing else
`ifndef FRUSTUM_CULL_SPHERE_BOX_DEFINES_SVH
`define FRUSTUM_CULL_SPHERE_BOX_DEFINES_SVH

// property checked only outside reset
`define FCSB_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// property checked at every edge, reset included
`define FCSB_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[hdl/fcsb_pkg.sv]
// shared types and constants of the frustum culling block
// no dependencies
package fcsb_pkg;

   localparam int PLANE_COUNT_DEFAULT = 6;
   localparam int COORD_W             = 16;
   localparam int NORM_W              = 16;
   localparam int RADIUS_W            = 15;
   localparam int PLANE_W             = 64;

   // plane register layout: nx, ny, nz, then the offset
   localparam int OFFSET_LSB          = 3 * NORM_W;

   // widths of the internal arithmetic
   localparam int SUM_W               = COORD_W + 1;
   localparam int ABSN_W              = NORM_W + 2;
   localparam int PROD_D_W            = NORM_W + SUM_W;
   localparam int PROD_R_W            = SUM_W + ABSN_W;
   localparam int ACC_W               = 38;

   // sphere offsets and radii are scaled by 2^14, boxes (doubled) by 2^15
   localparam int SPHERE_SHIFT        = 14;
   localparam int BOX_SHIFT           = 15;

   typedef struct packed {
      logic [RADIUS_W-1:0]       sphere_radius;
      logic signed [COORD_W-1:0] point_b_z;
      logic signed [COORD_W-1:0] point_b_y;
      logic signed [COORD_W-1:0] point_b_x;
      logic signed [COORD_W-1:0] point_a_z;
      logic signed [COORD_W-1:0] point_a_y;
      logic signed [COORD_W-1:0] point_a_x;
   } item_type;

   localparam int ITEM_W      = $bits(item_type);
   localparam int REQ_TDATA_W = ((ITEM_W + 7) / 8) * 8;
   localparam int RSP_TDATA_W = 8;

   // item, kind and the running verdict handed from cell to cell
   typedef struct packed {
      item_type item;
      logic     kind;
      logic     visible;
   } token_type;

endpackage

[hdl/fcsb_cell.sv]
// one plane cell: holds one plane register and tests the passing item against it
// three stages: products, sums, compare; depends on fcsb_pkg
module fcsb_cell
   import fcsb_pkg::*;
#(
   parameter int IDX_W      = 3,
   parameter int CELL_INDEX = 0
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_valid,
   input  logic [IDX_W-1:0]   csr_index,
   input  logic [PLANE_W-1:0] csr_data,
   input  logic               in_valid,
   output logic               in_ready,
   input  token_type          in_token,
   output logic               out_valid,
   input  logic               out_ready,
   output token_type          out_token
);

   logic [PLANE_W-1:0] plane_ff;

   logic signed [NORM_W-1:0]   norm_v  [3];
   logic signed [COORD_W-1:0]  a_v     [3];
   logic signed [COORD_W-1:0]  b_v     [3];
   logic signed [SUM_W-1:0]    s_v     [3];
   logic signed [SUM_W-1:0]    e_v     [3];
   logic signed [ABSN_W-1:0]   absn_v  [3];

   logic signed [PROD_D_W-1:0] prod_d_in [3];
   logic signed [PROD_D_W-1:0] prod_d_ff [3];
   logic signed [PROD_R_W-1:0] prod_r_in [3];
   logic signed [PROD_R_W-1:0] prod_r_ff [3];
   logic signed [COORD_W-1:0]  offset_in;
   logic signed [COORD_W-1:0]  offset_ff;
   token_type                  tok1_ff;
   logic                       v1_ff;

   logic signed [ACC_W-1:0]    dist_in;
   logic signed [ACC_W-1:0]    dist_ff;
   logic signed [ACC_W-1:0]    reach_in;
   logic signed [ACC_W-1:0]    reach_ff;
   token_type                  tok2_ff;
   logic                       v2_ff;

   logic signed [ACC_W-1:0]    reach_v;
   logic signed [ACC_W-1:0]    margin_v;
   token_type                  tok3_in;
   token_type                  tok3_ff;
   logic                       v3_ff;

   logic ready1, ready2, ready3;

   // plane register
   always_ff @(posedge clock) begin
      if (reset) begin
         plane_ff <= '0;
      end else if (csr_valid && csr_index == IDX_W'(CELL_INDEX)) begin
         plane_ff <= csr_data;
      end
   end

   // stall handling: a stage loads when it is empty or its successor moves
   assign ready3   = !v3_ff || out_ready;
   assign ready2   = !v2_ff || ready3;
   assign ready1   = !v1_ff || ready2;
   assign in_ready = ready1;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
      end else begin
         if (ready1) begin
            v1_ff <= in_valid;
         end
         if (ready2) begin
            v2_ff <= v1_ff;
         end
         if (ready3) begin
            v3_ff <= v2_ff;
         end
      end
   end

   // stage 1: per-axis products
   always_comb begin
      norm_v[0] = $signed(plane_ff[NORM_W-1:0]);
      norm_v[1] = $signed(plane_ff[2*NORM_W-1:NORM_W]);
      norm_v[2] = $signed(plane_ff[3*NORM_W-1:2*NORM_W]);
      offset_in = $signed(plane_ff[OFFSET_LSB+COORD_W-1:OFFSET_LSB]);
      a_v[0] = in_token.item.point_a_x;
      a_v[1] = in_token.item.point_a_y;
      a_v[2] = in_token.item.point_a_z;
      b_v[0] = in_token.item.point_b_x;
      b_v[1] = in_token.item.point_b_y;
      b_v[2] = in_token.item.point_b_z;
      for (int i = 0; i < 3; i++) begin
         // box works on min+max and max-min, the whole test doubled
         s_v[i]       = in_token.kind ? (SUM_W'(a_v[i]) + SUM_W'(b_v[i])) : SUM_W'(a_v[i]);
         e_v[i]       = SUM_W'(b_v[i]) - SUM_W'(a_v[i]);
         absn_v[i]    = norm_v[i][NORM_W-1] ? -ABSN_W'(norm_v[i]) : ABSN_W'(norm_v[i]);
         prod_d_in[i] = PROD_D_W'(norm_v[i]) * PROD_D_W'(s_v[i]);
         prod_r_in[i] = PROD_R_W'(e_v[i]) * PROD_R_W'(absn_v[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (ready1) begin
         tok1_ff   <= in_token;
         offset_ff <= offset_in;
         for (int i = 0; i < 3; i++) begin
            prod_d_ff[i] <= prod_d_in[i];
            prod_r_ff[i] <= prod_r_in[i];
         end
      end
   end

   // stage 2: signed distance and raw box reach
   always_comb begin
      dist_in = ACC_W'(prod_d_ff[0]) + ACC_W'(prod_d_ff[1]) + ACC_W'(prod_d_ff[2])
              + (tok1_ff.kind ? (ACC_W'(offset_ff) <<< BOX_SHIFT)
                              : (ACC_W'(offset_ff) <<< SPHERE_SHIFT));
      reach_in = ACC_W'(prod_r_ff[0]) + ACC_W'(prod_r_ff[1]) + ACC_W'(prod_r_ff[2]);
   end

   always_ff @(posedge clock) begin
      if (ready2) begin
         tok2_ff  <= tok1_ff;
         dist_ff  <= dist_in;
         reach_ff <= reach_in;
      end
   end

   // stage 3: culled when distance + reach goes negative
   always_comb begin
      if (tok2_ff.kind) begin
         // inverted boxes give a negative sum, so take its magnitude
         reach_v = reach_ff[ACC_W-1] ? -reach_ff : reach_ff;
      end else begin
         reach_v = $signed(ACC_W'(tok2_ff.item.sphere_radius) << SPHERE_SHIFT);
      end
      margin_v        = dist_ff + reach_v;
      tok3_in         = tok2_ff;
      tok3_in.visible = tok2_ff.visible && !margin_v[ACC_W-1];
   end

   always_ff @(posedge clock) begin
      if (ready3) begin
         tok3_ff <= tok3_in;
      end
   end

   assign out_valid = v3_ff;
   assign out_token = tok3_ff;

endmodule

[hdl/frustum_cull_sphere_box.sv]
// One item per clock while req_tready is high: a sphere or an axis-aligned box enters on req_
// and leaves as a visible flag on rsp_, in order, after passing through the row of plane cells,
// each a three-stage pipeline (products, sums, compare). Stalls on rsp_ fill bubbles first, so
// req_tready drops only when every stage is full. Plane registers are written through csr_;
// the user must write them only while the block is idle, which the block does not enforce.
// Index i selects plane i (left, right, top, bottom, near, far), other indexes are ignored.
// All planes reset to zero, making every volume visible. Depends on fcsb_pkg and fcsb_cell.
module frustum_cull_sphere_box
   import fcsb_pkg::*;
#(
   parameter int PLANE_COUNT = PLANE_COUNT_DEFAULT,
   parameter int IDX_W       = $clog2(PLANE_COUNT)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   output logic                   req_tready,
   // a_x, a_y, a_z, b_x, b_y, b_z, sphere_radius, zero pad
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   // kind (0 sphere, 1 box)
   input  logic                   req_tuser,
   output logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // visible, zero pad
   output logic [RSP_TDATA_W-1:0] rsp_tdata,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [IDX_W-1:0]       csr_index,
   input  logic [PLANE_W-1:0]     csr_data
);

   logic      link_valid [PLANE_COUNT+1];
   logic      link_ready [PLANE_COUNT+1];
   token_type link_token [PLANE_COUNT+1];

   assign csr_ready = 1'b1;

   always_comb begin
      link_token[0].item    = item_type'(req_tdata[ITEM_W-1:0]);
      link_token[0].kind    = req_tuser;
      link_token[0].visible = 1'b1;
   end

   assign link_valid[0] = req_tvalid;
   assign req_tready    = link_ready[0];

   for (genvar g = 0; g < PLANE_COUNT; g++) begin : g_cell
      fcsb_cell #(
         .IDX_W      (IDX_W),
         .CELL_INDEX (g)
      ) u_cell (
         .clock     (clock),
         .reset     (reset),
         .csr_valid (csr_valid),
         .csr_index (csr_index),
         .csr_data  (csr_data),
         .in_valid  (link_valid[g]),
         .in_ready  (link_ready[g]),
         .in_token  (link_token[g]),
         .out_valid (link_valid[g+1]),
         .out_ready (link_ready[g+1]),
         .out_token (link_token[g+1])
      );
   end

   assign rsp_tvalid              = link_valid[PLANE_COUNT];
   assign link_ready[PLANE_COUNT] = rsp_tready;
   assign rsp_tdata               = RSP_TDATA_W'(link_token[PLANE_COUNT].visible);

endmodule

[hdl/fcsb_chk.sv]
// port-level checker for the frustum culling block, bound to the top level
// depends on fcsb_pkg and frustum_cull_sphere_box_defines.svh
`include "frustum_cull_sphere_box_defines.svh"

module fcsb_chk
   import fcsb_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   req_tvalid,
   input logic                   req_tready,
   input logic                   rsp_tvalid,
   input logic                   rsp_tready,
   input logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // a stalled result holds its flag
   `FCSB_ASSERT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata), "rsp item changed while stalled")

   // reset empties the pipeline
   `FCSB_ASSERT_ALWAYS(a_reset_empty, clock, reset |=> !rsp_tvalid, "result right after reset")

   // input backpressure only when the output is blocked
   `FCSB_ASSERT(a_req_stall, clock, reset, !req_tready |-> rsp_tvalid && !rsp_tready, "req stalled with output free")

   // padding above the flag stays zero
   `FCSB_ASSERT(a_rsp_pad, clock, reset, rsp_tvalid |-> rsp_tdata[RSP_TDATA_W-1:1] == '0, "rsp padding not zero")

endmodule

bind frustum_cull_sphere_box fcsb_chk u_fcsb_chk (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

[bench/frustum_cull_sphere_box_tb.sv]
// self-checking bench for frustum_cull_sphere_box: spheres and boxes against six planes
// predicts most flags in plain integer math; depends on fcsb_pkg and the block
module frustum_cull_sphere_box_tb;
   import fcsb_pkg::*;

   localparam int PLANES       = 6;
   localparam int IDX_W        = $clog2(PLANES);
   localparam int SETTLE_CYCLES = 3 * PLANES + 6;
   localparam int RAND_PHASES  = 7;
   localparam int PHASE_ITEMS  = 215;

   localparam bit KIND_SPHERE = 1'b0;
   localparam bit KIND_BOX    = 1'b1;

   // register indexes
   localparam int PLANE_LEFT   = 0;
   localparam int PLANE_RIGHT  = 1;
   localparam int PLANE_TOP    = 2;
   localparam int PLANE_BOTTOM = 3;
   localparam int PLANE_NEAR   = 4;
   localparam int PLANE_FAR    = 5;

   // plane setting styles
   localparam int CFG_ZERO    = 0;
   localparam int CFG_FRUSTUM = 1;
   localparam int CFG_RANDOM  = 2;
   localparam int CFG_EXTREME = 3;
   localparam int CFG_MIXED   = 4;

   // expected flag of a directed row
   localparam logic [1:0] WANT_HIDDEN  = 2'd0;
   localparam logic [1:0] WANT_SHOWN   = 2'd1;
   localparam logic [1:0] WANT_PREDICT = 2'd2;

   localparam int PHASE_STYLE [RAND_PHASES] =
      '{CFG_FRUSTUM, CFG_RANDOM, CFG_EXTREME, CFG_FRUSTUM, CFG_MIXED, CFG_FRUSTUM, CFG_EXTREME};

   localparam logic [15:0] CORNER_VALS [6] =
      '{16'h8000, 16'h7FFF, 16'h0000, 16'hFFFF, 16'h4000, 16'hC000};

   // box x in [0, 1600], y in [-1600, 1600], z in [0, 1600]; packing {w, nz, ny, nx}
   localparam logic [63:0] TEST_FRUSTUM [PLANES] = '{
      {16'd0,    16'h0000, 16'h0000, 16'h4000},
      {16'd1600, 16'h0000, 16'h0000, 16'hC000},
      {16'd1600, 16'h0000, 16'hC000, 16'h0000},
      {16'd1600, 16'h0000, 16'h4000, 16'h0000},
      {16'd0,    16'h4000, 16'h0000, 16'h0000},
      {16'd1600, 16'hC000, 16'h0000, 16'h0000}};

   typedef struct packed {
      logic              kind;
      logic signed [15:0] ax;
      logic signed [15:0] ay;
      logic signed [15:0] az;
      logic signed [15:0] bx;
      logic signed [15:0] by;
      logic signed [15:0] bz;
      logic [14:0]        radius;
      logic [1:0]         want;
   } stim_row_type;

   localparam int ZERO_ROWS = 6;
   localparam int DIR_ROWS  = 24;

   // first rows run on reset planes, the rest on the test frustum
   localparam stim_row_type DIRECTED [DIR_ROWS] = '{
      '{KIND_SPHERE, 0, 0, 0, 0, 0, 0, 0, WANT_SHOWN},
      '{KIND_SPHERE, 32767, 32767, 32767, 0, 0, 0, 32767, WANT_SHOWN},
      '{KIND_SPHERE, -32768, -32768, -32768, 0, 0, 0, 0, WANT_SHOWN},
      '{KIND_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0, WANT_SHOWN},
      '{KIND_BOX, 32767, 32767, 32767, -32768, -32768, -32768, 0, WANT_SHOWN},
      '{KIND_BOX, -32768, -32768, -32768, -32768, -32768, -32768, 32767, WANT_SHOWN},
      '{KIND_SPHERE, 800, 0, 0, 0, 0, 0, 0, WANT_SHOWN},
      '{KIND_SPHERE, -100, 0, 0, 0, 0, 0, 10, WANT_HIDDEN},
      '{KIND_SPHERE, -100, 0, 0, 0, 0, 0, 100, WANT_SHOWN},
      '{KIND_SPHERE, -101, 0, 0, 0, 0, 0, 100, WANT_PREDICT},
      '{KIND_SPHERE, 0, 0, -1, 0, 0, 0, 0, WANT_HIDDEN},
      '{KIND_SPHERE, 1601, 0, 0, 0, 0, 0, 0, WANT_PREDICT},
      '{KIND_SPHERE, -32768, -32768, -32768, 0, 0, 0, 32767, WANT_PREDICT},
      '{KIND_SPHERE, 32767, 32767, 32767, 0, 0, 0, 32767, WANT_PREDICT},
      '{KIND_BOX, -10, -10, 0, 10, 10, 10, 0, WANT_PREDICT},
      '{KIND_BOX, -50, 0, 0, -10, 0, 0, 0, WANT_PREDICT},
      '{KIND_BOX, 10, 0, 0, -10, 0, 0, 0, WANT_PREDICT},
      '{KIND_BOX, -10, 0, 0, -50, 0, 0, 0, WANT_PREDICT},
      '{KIND_BOX, 1590, 0, 0, 1610, 0, 0, 0, WANT_PREDICT},
      '{KIND_BOX, -32768, -32768, -32768, 32767, 32767, 32767, 0, WANT_PREDICT},
      '{KIND_BOX, -32768, -32768, -32768, -32768, -32768, -32768, 0, WANT_PREDICT},
      '{KIND_BOX, 32767, 32767, 32767, -32768, -32768, -32768, 0, WANT_PREDICT},
      '{KIND_SPHERE, 5, 5, 5, -32768, -32768, -32768, 0, WANT_PREDICT},
      '{KIND_BOX, -50, 0, 0, -10, 0, 0, 32767, WANT_PREDICT}};

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_tvalid = 1'b0;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata = '0;
   logic                   req_tuser = 1'b0;
   logic                   rsp_tvalid;
   logic                   rsp_tready = 1'b0;
   logic [RSP_TDATA_W-1:0] rsp_tdata;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [IDX_W-1:0]       csr_index = '0;
   logic [PLANE_W-1:0]     csr_data = '0;

   logic [63:0] plane_cfg [PLANES];
   bit          visible_due [$];
   bit          pending_flag = 1'b0;
   bit          req_steady = 1'b0;
   bit          rsp_steady = 1'b0;
   int          errors = 0;

   frustum_cull_sphere_box DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   always #10 clock = ~clock;

   initial begin
      #20_000_000;
      $display("FAIL frustum_cull_sphere_box");
      $finish;
   end

   task automatic report_mismatch(input string what, input int got, input int want);
      $display("mismatch %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
      errors++;
   endtask

   // full-precision plane tests; sphere terms scaled by 2^14, doubled box terms by 2^15
   function automatic bit volume_visible(input bit is_box, input item_type it);
      longint n [3];
      longint a [3];
      longint b [3];
      longint w, distance, reach, rad;
      bit     vis;
      a[0] = it.point_a_x;
      a[1] = it.point_a_y;
      a[2] = it.point_a_z;
      b[0] = it.point_b_x;
      b[1] = it.point_b_y;
      b[2] = it.point_b_z;
      rad  = it.sphere_radius;
      vis  = 1'b1;
      for (int p = 0; p < PLANES; p++) begin
         n[0]     = $signed(plane_cfg[p][15:0]);
         n[1]     = $signed(plane_cfg[p][31:16]);
         n[2]     = $signed(plane_cfg[p][47:32]);
         w        = $signed(plane_cfg[p][63:48]);
         distance = 0;
         reach    = 0;
         if (!is_box) begin
            for (int i = 0; i < 3; i++)
               distance += n[i] * a[i];
            distance += w * 16384;
            if (distance < -(rad * 16384))
               vis = 1'b0;
         end else begin
            for (int i = 0; i < 3; i++) begin
               distance += n[i] * (a[i] + b[i]);
               reach    += (b[i] - a[i]) * (n[i] < 0 ? -n[i] : n[i]);
            end
            distance += w * 32768;
            // inverted extents still give a non-negative reach
            if (reach < 0)
               reach = -reach;
            if (distance < -reach)
               vis = 1'b0;
         end
      end
      return vis;
   endfunction

   function automatic int gap_len();
      int r;
      r = $urandom_range(0, 99);
      if (r < 65)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(12, 40);
   endfunction

   function automatic logic [63:0] pick_plane(input int style);
      logic [63:0] p;
      int          s;
      s = (style == CFG_MIXED) ? $urandom_range(CFG_ZERO, CFG_EXTREME) : style;
      case (s)
         CFG_ZERO: begin
            p = '0;
         end
         CFG_FRUSTUM: begin
            p[15:0]  = 16'($urandom_range(0, 32768) - 16384);
            p[31:16] = 16'($urandom_range(0, 32768) - 16384);
            p[47:32] = 16'($urandom_range(0, 32768) - 16384);
            p[63:48] = 16'($urandom_range(0, 8191) - 4096);
         end
         CFG_EXTREME: begin
            for (int k = 0; k < 4; k++)
               p[16*k +: 16] = CORNER_VALS[$urandom_range(0, 5)];
         end
         default: begin
            p = {$urandom(), $urandom()};
         end
      endcase
      return p;
   endfunction

   function automatic logic signed [15:0] corner_coord();
      case ($urandom_range(0, 3))
         0: return -16'sd32768;
         1: return 16'sd32767;
         2: return 16'sd0;
         default: return -16'sd1;
      endcase
   endfunction

   // mostly volumes near the frustum, then full-range noise and corner values
   function automatic item_type make_volume(input bit is_box);
      item_type it;
      int       sel;
      int       ext;
      sel = $urandom_range(0, 99);
      if (sel < 55) begin
         it.point_a_x = 16'($urandom_range(0, 4095) - 2048);
         it.point_a_y = 16'($urandom_range(0, 4095) - 2048);
         it.point_a_z = 16'($urandom_range(0, 4095) - 2048);
         if (is_box) begin
            ext = (sel < 47) ? 1 : -1;
            it.point_b_x = it.point_a_x + 16'(ext * $urandom_range(0, 1023));
            it.point_b_y = it.point_a_y + 16'(ext * $urandom_range(0, 1023));
            it.point_b_z = it.point_a_z + 16'(ext * $urandom_range(0, 1023));
         end else begin
            it.point_b_x = 16'($urandom());
            it.point_b_y = 16'($urandom());
            it.point_b_z = 16'($urandom());
         end
         it.sphere_radius = 15'($urandom_range(0, 1023));
      end else if (sel < 85) begin
         it = item_type'(ITEM_W'({$urandom(), $urandom(), $urandom(), $urandom()}));
      end else begin
         it.point_a_x = corner_coord();
         it.point_a_y = corner_coord();
         it.point_a_z = corner_coord();
         it.point_b_x = corner_coord();
         it.point_b_y = corner_coord();
         it.point_b_z = corner_coord();
         it.sphere_radius = $urandom_range(0, 1) ? 15'h7FFF : 15'($urandom_range(0, 1));
      end
      return it;
   endfunction

   task automatic write_plane(input int idx, input logic [63:0] value);
      @(negedge clock);
      csr_valid = 1'b1;
      csr_index = IDX_W'(idx);
      csr_data  = value;
      do @(posedge clock); while (!csr_ready);
      if (idx < PLANES)
         plane_cfg[idx] = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // valid stays high across back-to-back items
   task automatic push_volume(input bit is_box, input item_type it, input bit flag);
      @(negedge clock);
      req_tvalid   = 1'b1;
      req_tuser    = is_box;
      req_tdata    = {{(REQ_TDATA_W - ITEM_W){1'b0}}, it};
      pending_flag = flag;
      do @(posedge clock); while (!req_tready);
   endtask

   task automatic sender_pause(input int cycles);
      @(negedge clock);
      req_tvalid = 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (visible_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // results are checked before the item taken at the same edge is queued
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            if (visible_due.size() == 0)
               report_mismatch("unexpected visible item", rsp_tdata[0], -1);
            else if (rsp_tdata[0] !== visible_due[0]) begin
               report_mismatch("visible", rsp_tdata[0], visible_due[0]);
               void'(visible_due.pop_front());
            end else
               void'(visible_due.pop_front());
         end
         if (req_tvalid && req_tready)
            visible_due.push_back(pending_flag);
      end
   end

   initial begin
      int hold;
      hold = 0;
      forever begin
         @(negedge clock);
         if (hold > 0) begin
            rsp_tready = 1'b0;
            hold--;
         end else begin
            rsp_tready = 1'b1;
            if (!rsp_steady)
               hold = gap_len();
         end
      end
   end

   initial begin
      item_type     it;
      stim_row_type row;
      bit           is_box;
      bit           flag;
      int           gap;

      for (int p = 0; p < PLANES; p++)
         plane_cfg[p] = '0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      for (int r = 0; r < DIR_ROWS; r++) begin
         if (r == ZERO_ROWS) begin
            drain_results();
            write_plane(PLANE_LEFT,   TEST_FRUSTUM[PLANE_LEFT]);
            write_plane(PLANE_RIGHT,  TEST_FRUSTUM[PLANE_RIGHT]);
            write_plane(PLANE_TOP,    TEST_FRUSTUM[PLANE_TOP]);
            write_plane(PLANE_BOTTOM, TEST_FRUSTUM[PLANE_BOTTOM]);
            write_plane(PLANE_NEAR,   TEST_FRUSTUM[PLANE_NEAR]);
            write_plane(PLANE_FAR,    TEST_FRUSTUM[PLANE_FAR]);
            // indexes past the last plane must not touch anything
            write_plane(PLANES,     '1);
            write_plane(PLANES + 1, '1);
         end
         row = DIRECTED[r];
         it.point_a_x     = row.ax;
         it.point_a_y     = row.ay;
         it.point_a_z     = row.az;
         it.point_b_x     = row.bx;
         it.point_b_y     = row.by;
         it.point_b_z     = row.bz;
         it.sphere_radius = row.radius;
         flag = (row.want == WANT_PREDICT) ? volume_visible(row.kind, it) : row.want[0];
         push_volume(row.kind, it, flag);
         gap = gap_len();
         if (gap > 0)
            sender_pause(gap);
      end

      for (int ph = 0; ph < RAND_PHASES; ph++) begin
         drain_results();
         for (int p = 0; p < PLANES; p++)
            write_plane(p, pick_plane(PHASE_STYLE[ph]));
         if (ph % 2 == 1)
            write_plane($urandom_range(PLANES, (1 << IDX_W) - 1), {$urandom(), $urandom()});
         req_steady = (ph == 3);
         rsp_steady = (ph == 3) || (ph == 5 && $urandom_range(0, 1));
         for (int n = 0; n < PHASE_ITEMS; n++) begin
            // in phase 1, hold the sender until the pipe is empty once mid-phase
            if (ph == 1 && n == PHASE_ITEMS / 2)
               drain_results();
            is_box = $urandom_range(0, 1);
            it     = make_volume(is_box);
            push_volume(is_box, it, volume_visible(is_box, it));
            gap = req_steady ? 0 : gap_len();
            if (gap > 0)
               sender_pause(gap);
         end
      end

      rsp_steady = 1'b0;
      drain_results();
      if (errors == 0)
         $display("PASS frustum_cull_sphere_box");
      else
         $display("FAIL frustum_cull_sphere_box");
      $finish;
   end

endmodule

[files.f]
+incdir+hdl
hdl/fcsb_pkg.sv
hdl/fcsb_cell.sv
hdl/frustum_cull_sphere_box.sv
hdl/fcsb_chk.sv
bench/frustum_cull_sphere_box_tb.sv
